>>> hw/rtl/pcp_pkg.sv
// Shared types, constants and lookup functions of the point chunk parser.
package pcp_pkg;

	// Chunk layout.
	localparam int unsigned POS_W           = 27;
	localparam logic [POS_W-1:0] MAX_CHUNK_BYTES = 27'd67108864;
	localparam logic [POS_W-1:0] MAGIC_BYTES     = 27'd8;
	localparam logic [POS_W-1:0] HEADER_BYTES    = 27'd16;
	localparam logic [4:0] STRIDE_XYZ       = 5'd12;
	localparam logic [4:0] STRIDE_RGB       = 5'd16;
	localparam logic [3:0] COORD_BYTES      = 4'd12;

	// Register widths.
	localparam int unsigned DECL_BYTES_W  = 27;
	localparam int unsigned DECL_POINTS_W = 23;
	localparam int unsigned POINTS_W      = 23;

	// Result queue.
	localparam int unsigned OUT_DEPTH = 8;
	localparam int unsigned OUT_AW    = 3;
	localparam int unsigned OUT_CW    = 4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_LENGTH    = 3'd2,
		ST_COUNT     = 3'd3,
		ST_NONFINITE = 3'd4
	} status_t;

	typedef enum logic {
		REG_DECL_BYTES  = 1'b0,
		REG_DECL_POINTS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        is_status;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
		logic        has_color;
		logic [2:0]  status;
		logic        end_of_chunk;
	} result_t;

	function automatic logic [7:0] magic_xyz_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h53;
			3'd1: b = 8'h44;
			3'd2: b = 8'h58;
			3'd3: b = 8'h59;
			3'd4: b = 8'h5A;
			3'd5: b = 8'h31;
			3'd6: b = 8'h00;
			3'd7: b = 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] magic_rgb_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h53;
			3'd1: b = 8'h44;
			3'd2: b = 8'h52;
			3'd3: b = 8'h47;
			3'd4: b = 8'h42;
			3'd5: b = 8'h31;
			3'd6: b = 8'h00;
			3'd7: b = 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// A word is finite unless its exponent field is all ones.
	function automatic logic word_finite(input logic [31:0] w);
		return w[30:23] != 8'hFF;
	endfunction

endpackage

>>> hw/rtl/pcp_stream_if.sv
// Valid/ready stream interfaces for the byte input and the result output.
interface pcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcp_out_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] z_bits;
	logic        has_color;
	logic [2:0]  status;
	logic        end_of_chunk;

	modport source (output valid, output is_status, output x_bits, output y_bits,
		output z_bits, output has_color, output status, output end_of_chunk, input ready);
	modport sink (input valid, input is_status, input x_bits, input y_bits,
		input z_bits, input has_color, input status, input end_of_chunk, output ready);
endinterface

>>> hw/rtl/point_chunk_parser.sv
// Point chunk parser: byte-stream checker and point decoder with APB registers.
//
//   Channel   Direction  Handshake       Moves per transfer
//   in_ch     sink       valid/ready     one chunk byte and its last-byte mark
//   out_ch    source     valid/ready     one point result or one status result
//   APB       slave      psel/penable    one register write or read
//
// The block takes one byte every cycle while in_ch.ready is high. A byte is
// registered on acceptance and processed in the following cycle. Its results
// are written into an eight-entry result queue at the end of that cycle and
// are offered on out_ch right away.
// arst_n clears the chunk counters, flags and both registers asynchronously; the
// point word registers are always rewritten before they are used.
// in_ch.ready drops only when the result queue, counting the byte under work,
// could not take the two results that a final byte may produce.
module point_chunk_parser
	import pcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pcp_in_if.sink      in_ch,
	pcp_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers. A write completes in the access phase; the
	// register index is the word address, so paddr[2] selects the register.
	logic [DECL_BYTES_W-1:0]  decl_bytes_q;
	logic [DECL_POINTS_W-1:0] decl_points_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_bytes_q  <= '0;
			decl_points_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_DECL_BYTES:  decl_bytes_q  <= pwdata[DECL_BYTES_W-1:0];
				REG_DECL_POINTS: decl_points_q <= pwdata[DECL_POINTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_DECL_BYTES:  prdata = {{(32-DECL_BYTES_W){1'b0}}, decl_bytes_q};
			REG_DECL_POINTS: prdata = {{(32-DECL_POINTS_W){1'b0}}, decl_points_q};
			default:         prdata = '0;
		endcase
	end

	// Input register. The byte is held here while it is processed.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       in_xfer;

	// Result queue bookkeeping.
	logic [OUT_CW-1:0] cnt_q;
	logic [OUT_AW-1:0] wr_q;
	logic [OUT_AW-1:0] rd_q;
	logic [OUT_CW-1:0] occupancy;
	result_t           queue_q [OUT_DEPTH];

	// The byte under work may push two results, so reserve room for it too.
	assign occupancy   = cnt_q + (valid_s1 ? OUT_CW'(2) : OUT_CW'(0));
	assign in_ch.ready = occupancy <= OUT_CW'(OUT_DEPTH - 2);
	assign in_xfer     = in_ch.valid & in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Chunk state.
	logic [POS_W-1:0]     pos_q;
	logic                 xyz_ok_q;
	logic                 rgb_ok_q;
	logic [63:0]          hdr_q;
	logic [2:0][31:0]     words_q;
	logic [3:0]           off_q;
	logic [POINTS_W-1:0]  pts_q;
	status_t              err_q;

	// Next values after the byte under work.
	logic [POS_W-1:0]     pos_d;
	logic                 xyz_ok_d;
	logic                 rgb_ok_d;
	logic [63:0]          hdr_d;
	logic [2:0][31:0]     words_d;
	logic [3:0]           off_d;
	logic [POINTS_W-1:0]  pts_d;
	status_t              err_d;

	logic [4:0]  off_inc;
	logic [4:0]  stride;
	logic        pt_push;
	logic        st_push;
	logic        pts_finite;
	status_t     fin_status;
	result_t     pt_res;
	result_t     st_res;

	always_comb begin
		pos_d      = pos_q;
		xyz_ok_d   = xyz_ok_q;
		rgb_ok_d   = rgb_ok_q;
		hdr_d      = hdr_q;
		words_d    = words_q;
		off_d      = off_q;
		pts_d      = pts_q;
		err_d      = err_q;
		pt_push    = 1'b0;
		pts_finite = 1'b0;
		stride     = rgb_ok_q ? STRIDE_RGB : STRIDE_XYZ;
		off_inc    = {1'b0, off_q} + 5'd1;

		if (valid_s1) begin
			if (pos_q < MAGIC_BYTES) begin
				// Both magics are tracked until the first mismatch of each.
				if (byte_s1 != magic_xyz_byte(pos_q[2:0])) begin
					xyz_ok_d = 1'b0;
				end
				if (byte_s1 != magic_rgb_byte(pos_q[2:0])) begin
					rgb_ok_d = 1'b0;
				end
				if (pos_q[2:0] == 3'd7 && !xyz_ok_d && !rgb_ok_d && err_q == ST_OK) begin
					err_d = ST_BAD_MAGIC;
				end
			end else if (pos_q < HEADER_BYTES) begin
				// Little-endian 64-bit point count, one byte lane per byte.
				hdr_d[{pos_q[2:0], 3'b000} +: 8] = byte_s1;
			end else if (pos_q < MAX_CHUNK_BYTES) begin
				// Coordinate bytes fill the three words; color bytes are skipped.
				if (off_q < COORD_BYTES) begin
					words_d[off_q[3:2]][{off_q[1:0], 3'b000} +: 8] = byte_s1;
				end
				if (off_inc >= stride) begin
					off_d      = '0;
					pts_d      = pts_q + POINTS_W'(1);
					pts_finite = word_finite(words_d[0]) & word_finite(words_d[1]) &
						word_finite(words_d[2]);
					if (err_q == ST_OK && pts_finite) begin
						pt_push = 1'b1;
					end else if (err_q == ST_OK) begin
						err_d = ST_NONFINITE;
					end
				end else begin
					off_d = off_inc[3:0];
				end
			end
			// The byte count saturates one past the limit.
			if (pos_q <= MAX_CHUNK_BYTES) begin
				pos_d = pos_q + POS_W'(1);
			end
		end
	end

	// Final status, checked in priority order on the counts after the last
	// byte. Since every payload byte below the limit is gathered, a whole
	// number of points means the point offset is back at zero, and the point
	// count then equals the payload length over the stride.
	always_comb begin
		if (decl_bytes_q > MAX_CHUNK_BYTES || pos_d != decl_bytes_q ||
				pos_d > MAX_CHUNK_BYTES) begin
			fin_status = ST_LENGTH;
		end else if (pos_d < HEADER_BYTES || (!rgb_ok_d && !xyz_ok_d)) begin
			fin_status = ST_BAD_MAGIC;
		end else if (off_d != 4'd0 || hdr_d != {{(64-POINTS_W){1'b0}}, pts_d} ||
				hdr_d != {{(64-DECL_POINTS_W){1'b0}}, decl_points_q}) begin
			fin_status = ST_COUNT;
		end else if (err_d == ST_NONFINITE) begin
			fin_status = ST_NONFINITE;
		end else begin
			fin_status = ST_OK;
		end
	end

	assign st_push = valid_s1 & last_s1;

	always_comb begin
		pt_res              = '0;
		pt_res.x_bits       = words_d[0];
		pt_res.y_bits       = words_d[1];
		pt_res.z_bits       = words_d[2];
		pt_res.has_color    = rgb_ok_q;

		st_res              = '0;
		st_res.is_status    = 1'b1;
		st_res.has_color    = (pos_d >= HEADER_BYTES) & rgb_ok_d;
		st_res.status       = fin_status;
		st_res.end_of_chunk = 1'b1;
	end

	// State update; the final byte returns the chunk state to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			xyz_ok_q <= 1'b1;
			rgb_ok_q <= 1'b1;
			hdr_q    <= '0;
			off_q    <= '0;
			pts_q    <= '0;
			err_q    <= ST_OK;
		end else if (st_push) begin
			pos_q    <= '0;
			xyz_ok_q <= 1'b1;
			rgb_ok_q <= 1'b1;
			hdr_q    <= '0;
			off_q    <= '0;
			pts_q    <= '0;
			err_q    <= ST_OK;
		end else begin
			pos_q    <= pos_d;
			xyz_ok_q <= xyz_ok_d;
			rgb_ok_q <= rgb_ok_d;
			hdr_q    <= hdr_d;
			off_q    <= off_d;
			pts_q    <= pts_d;
			err_q    <= err_d;
		end
	end

	// Every word byte is overwritten before a point completes, so the word
	// registers need no clearing.
	always_ff @(posedge clk) begin
		words_q <= words_d;
	end

	// Result queue. A point completed by the final byte goes in ahead of the
	// status result.
	logic              pop;
	logic [1:0]        push_n;
	logic [OUT_AW-1:0] wr_next;

	assign pop     = out_ch.valid & out_ch.ready;
	assign push_n  = {1'b0, pt_push} + {1'b0, st_push};
	assign wr_next = wr_q + OUT_AW'(1);

	always_ff @(posedge clk) begin
		if (pt_push) begin
			queue_q[wr_q] <= pt_res;
			if (st_push) begin
				queue_q[wr_next] <= st_res;
			end
		end else if (st_push) begin
			queue_q[wr_q] <= st_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OUT_AW'(push_n);
			rd_q  <= rd_q + (pop ? OUT_AW'(1) : OUT_AW'(0));
			cnt_q <= cnt_q + OUT_CW'(push_n) - (pop ? OUT_CW'(1) : OUT_CW'(0));
		end
	end

	assign out_ch.valid        = cnt_q != '0;
	assign out_ch.is_status    = queue_q[rd_q].is_status;
	assign out_ch.x_bits       = queue_q[rd_q].x_bits;
	assign out_ch.y_bits       = queue_q[rd_q].y_bits;
	assign out_ch.z_bits       = queue_q[rd_q].z_bits;
	assign out_ch.has_color    = queue_q[rd_q].has_color;
	assign out_ch.status       = queue_q[rd_q].status;
	assign out_ch.end_of_chunk = queue_q[rd_q].end_of_chunk;

	// The queue never holds more results than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_CW'(OUT_DEPTH))
		else $error("result queue overflow");

	// A final byte leaves the chunk state at its start.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (pos_q == '0 && err_q == ST_OK))
		else $error("chunk state not cleared after final byte");

	// No error is recorded before the magic has been seen in full.
	a_no_early_err: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q < MAGIC_BYTES) |-> (err_q == ST_OK))
		else $error("error set inside the magic");

	// Without color the point offset stays inside the 12-byte stride.
	a_xyz_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q >= HEADER_BYTES && !rgb_ok_q) |-> (off_q < COORD_BYTES))
		else $error("point offset beyond stride");

endmodule
